[rtl/core/cwmc_pkg.sv]
// ----------------------------------------------------------------------------
// cwmc_pkg
// Shared types, constants and the colour window test for the mask/centroid
// block.
// ----------------------------------------------------------------------------
package cwmc_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 2048;

	localparam int PosW   = 11;           // column/row position
	localparam int WidthW = 12;           // frame_width register
	localparam int SumW   = 33;           // position sums
	localparam int CntW   = 23;           // match count
	localparam int CoordW = 12;           // centroid fields
	localparam int DivSteps = PosW;       // quotient bits, mean is below 2048

	localparam logic [2:0] CFG_TARGET_BLUE  = 3'd0;
	localparam logic [2:0] CFG_TARGET_GREEN = 3'd1;
	localparam logic [2:0] CFG_TARGET_RED   = 3'd2;
	localparam logic [2:0] CFG_TOL_BLUE     = 3'd3;
	localparam logic [2:0] CFG_TOL_GREEN    = 3'd4;
	localparam logic [2:0] CFG_TOL_RED      = 3'd5;
	localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd6;

	typedef struct packed {
		logic accept;      // input item taken this cycle
		logic div_step;    // one restoring division step
		logic load_pixel;  // output register takes a plain pixel result
		logic load_frame;  // output register takes the frame result
	} cwmc_cmd_t;

	function automatic logic in_window(logic [7:0] sample, logic [7:0] target,
	                                   logic [7:0] tol);
		logic [7:0] t;
		logic [7:0] headroom;
		t = tol;
		if (target < t) t = target;
		headroom = 8'd255 - target;
		if (t > headroom) t = headroom;
		return (sample >= target - t) && (sample <= target + t);
	endfunction

endpackage

[rtl/core/cwmc_ctrl.sv]
// ----------------------------------------------------------------------------
// cwmc_ctrl
// Controller: handshakes, frame-end division sequencing, output valid.
// ----------------------------------------------------------------------------
module cwmc_ctrl
	import cwmc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tlast,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output cwmc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [3:0] LastStep = 4'(DivSteps - 1);

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = s_tvalid && s_tready;
		cmd.load_pixel = cmd.accept && !s_tlast;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.load_frame = (state_q == ST_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_pixel || cmd.load_frame) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (cmd.accept && s_tlast) state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == LastStep) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/cwmc_dp.sv]
// ----------------------------------------------------------------------------
// cwmc_dp
// Datapath: config registers, window test, position tracking, sums and
// count, restoring division of both coordinates by one shared divisor register, output register.
// ----------------------------------------------------------------------------
module cwmc_dp
	import cwmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [11:0]       cfg_data,
	input  logic [7:0]        pixel_blue,
	input  logic [7:0]        pixel_green,
	input  logic [7:0]        pixel_red,
	input  logic              frame_last,
	input  cwmc_cmd_t         cmd,
	output logic              mask_on,
	output logic              frame_done,
	output logic [CoordW-1:0] center_x,
	output logic [CoordW-1:0] center_y
);

	logic [7:0]        target_blue_q, target_green_q, target_red_q;
	logic [7:0]        tol_blue_q, tol_green_q, tol_red_q;
	logic [WidthW-1:0] frame_width_q;

	logic [PosW-1:0] col_q, row_q;
	logic [SumW-1:0] sum_col_q, sum_row_q;
	logic [CntW-1:0] count_q;

	logic [SumW-1:0] rem_x_q, rem_y_q, div_sh_q;
	logic [PosW-1:0] quo_x_q, quo_y_q;
	logic            zero_q, hit_last_q;

	logic [WidthW-1:0] width_eff, col_next;
	logic [PosW-1:0]   col_cur;
	logic              hit, add;
	logic [SumW-1:0]   sum_col_new, sum_row_new;
	logic [CntW-1:0]   count_new;
	logic              ge_x, ge_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_blue_q  <= 8'd0;
			target_green_q <= 8'd0;
			target_red_q   <= 8'd0;
			tol_blue_q     <= 8'd15;
			tol_green_q    <= 8'd15;
			tol_red_q      <= 8'd15;
			frame_width_q  <= 12'd640;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_TARGET_BLUE:  target_blue_q  <= cfg_data[7:0];
				CFG_TARGET_GREEN: target_green_q <= cfg_data[7:0];
				CFG_TARGET_RED:   target_red_q   <= cfg_data[7:0];
				CFG_TOL_BLUE:     tol_blue_q     <= cfg_data[7:0];
				CFG_TOL_GREEN:    tol_green_q    <= cfg_data[7:0];
				CFG_TOL_RED:      tol_red_q      <= cfg_data[7:0];
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) width_eff = WidthW'(1);
		else if (frame_width_q > WidthW'(MaxWidth)) width_eff = WidthW'(MaxWidth);
		else width_eff = frame_width_q;

		col_cur  = ({1'b0, col_q} >= width_eff) ? '0 : col_q;
		col_next = {1'b0, col_cur} + WidthW'(1);

		hit = in_window(pixel_blue, target_blue_q, tol_blue_q) &&
		      in_window(pixel_green, target_green_q, tol_green_q) &&
		      in_window(pixel_red, target_red_q, tol_red_q);
		add = hit && !count_q[CntW-1];

		sum_col_new = add ? sum_col_q + SumW'(col_cur) : sum_col_q;
		sum_row_new = add ? sum_row_q + SumW'(row_q) : sum_row_q;
		count_new   = add ? count_q + CntW'(1) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			sum_col_q <= '0;
			sum_row_q <= '0;
			count_q   <= '0;
		end else if (cmd.accept) begin
			if (frame_last) begin
				col_q     <= '0;
				row_q     <= '0;
				sum_col_q <= '0;
				sum_row_q <= '0;
				count_q   <= '0;
			end else begin
				sum_col_q <= sum_col_new;
				sum_row_q <= sum_row_new;
				count_q   <= count_new;
				if (col_next >= width_eff) begin
					col_q <= '0;
					if (row_q != PosW'(MaxHeight - 1)) row_q <= row_q + PosW'(1);
				end else begin
					col_q <= col_next[PosW-1:0];
				end
			end
		end
	end

	// divisor starts at count << (DivSteps-1) and slides right each step
	assign ge_x = rem_x_q >= div_sh_q;
	assign ge_y = rem_y_q >= div_sh_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && frame_last) begin
			rem_x_q    <= sum_col_new;
			rem_y_q    <= sum_row_new;
			div_sh_q   <= {count_new, (DivSteps - 1)'(0)};
			quo_x_q    <= '0;
			quo_y_q    <= '0;
			zero_q     <= (count_new == '0);
			hit_last_q <= hit;
		end else if (cmd.div_step) begin
			if (ge_x) rem_x_q <= rem_x_q - div_sh_q;
			if (ge_y) rem_y_q <= rem_y_q - div_sh_q;
			quo_x_q  <= {quo_x_q[PosW-2:0], ge_x};
			quo_y_q  <= {quo_y_q[PosW-2:0], ge_y};
			div_sh_q <= {1'b0, div_sh_q[SumW-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			mask_on    <= hit;
			frame_done <= 1'b0;
			center_x   <= '0;
			center_y   <= '0;
		end else if (cmd.load_frame) begin
			mask_on    <= hit_last_q;
			frame_done <= 1'b1;
			center_x   <= zero_q ? '1 : {1'b0, quo_x_q};
			center_y   <= zero_q ? '1 : {1'b0, quo_y_q};
		end
	end

endmodule

[rtl/core/color_window_mask_centroid.sv]
// ----------------------------------------------------------------------------
// color_window_mask_centroid
// Colour-window mask and blob centroid over a raster stream of BGR pixels.
// ----------------------------------------------------------------------------
// Each pixel item gives one result item carrying its mask bit. Ordinary
// pixels go through back to back while the receiver takes the results, each
// result registered in the output register. The item marked last in a frame
// starts a restoring division of the column and row sums by the match count,
// one quotient bit per cycle. Its result, with tlast set and the centroid or
// -1,-1 when nothing matched, is loaded once the division is done and the
// output register is free, and the input is held off until then. A result
// left waiting in the output register holds off the next pixel until the
// receiver takes it.
module color_window_mask_centroid
	import cwmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16]
	input  logic        s_tlast,   // frame_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // mask_on[0], center_x[12:1], center_y[24:13], zero
	output logic        m_tlast    // frame_done
);

	cwmc_cmd_t         cmd;
	logic              mask_on;
	logic [CoordW-1:0] center_x, center_y;

	cwmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	cwmc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_blue  (s_tdata[7:0]),
		.pixel_green (s_tdata[15:8]),
		.pixel_red   (s_tdata[23:16]),
		.frame_last  (s_tlast),
		.cmd         (cmd),
		.mask_on     (mask_on),
		.frame_done  (m_tlast),
		.center_x    (center_x),
		.center_y    (center_y)
	);

	assign m_tdata = {7'd0, center_y, center_x, mask_on};

	a_last_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken during frame-end division");

	a_plain_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (center_x == '0 && center_y == '0))
		else $error("centroid set on a plain pixel result");

	a_none_both: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> ((center_x == '1) == (center_y == '1)))
		else $error("only one centroid coordinate marks no match");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for color_window_mask_centroid. A scoreboard holds its
// own copy of the colour windows, the raster position and the centroid sums,
// and predicts the mask bit and the frame centroid of every pixel item.
// Directed pixels cover the window edges, the clamping of the tolerance, a
// frame with no match and out-of-range frame widths. Random frames follow,
// under random settings, with random gaps on both streams and one long
// output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import cwmc_pkg::*;

	typedef struct packed {
		logic              mask;
		logic              done;
		logic [CoordW-1:0] cx;
		logic [CoordW-1:0] cy;
	} colour_result_t;

	class centroid_scoreboard;
		logic [7:0]  target_b, target_g, target_r;
		logic [7:0]  tol_b, tol_g, tol_r;
		logic [11:0] width_reg;
		int          col, row;
		longint      sum_col, sum_row, count;
		colour_result_t result_q[$];
		int          pixels, frames, empty_frames, hit_pixels, errors;

		function new();
			target_b = 8'd0;
			target_g = 8'd0;
			target_r = 8'd0;
			tol_b = 8'd15;
			tol_g = 8'd15;
			tol_r = 8'd15;
			width_reg = 12'd640;
			col = 0;
			row = 0;
			sum_col = 0;
			sum_row = 0;
			count = 0;
			pixels = 0;
			frames = 0;
			empty_frames = 0;
			hit_pixels = 0;
			errors = 0;
		endfunction

		// half-width of the window once the tolerance is clamped to keep it within 0..255
		function int reach(logic [7:0] target, logic [7:0] tol);
			int t;
			t = tol;
			if (t > int'(target)) t = target;
			if (t > 255 - int'(target)) t = 255 - int'(target);
			return t;
		endfunction

		function bit in_window(logic [7:0] sample, logic [7:0] target, logic [7:0] tol);
			int t;
			t = reach(target, tol);
			return int'(sample) >= int'(target) - t && int'(sample) <= int'(target) + t;
		endfunction

		function void set_reg(logic [2:0] idx, logic [11:0] data);
			case (idx)
				CFG_TARGET_BLUE:  target_b = data[7:0];
				CFG_TARGET_GREEN: target_g = data[7:0];
				CFG_TARGET_RED:   target_r = data[7:0];
				CFG_TOL_BLUE:     tol_b = data[7:0];
				CFG_TOL_GREEN:    tol_g = data[7:0];
				CFG_TOL_RED:      tol_r = data[7:0];
				CFG_FRAME_WIDTH:  width_reg = data;
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last);
			int             w;
			bit             hit;
			colour_result_t res;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > MaxWidth) w = MaxWidth;
			if (col >= w) col = 0;
			hit = in_window(b, target_b, tol_b) && in_window(g, target_g, tol_g) &&
			      in_window(r, target_r, tol_r);
			if (hit && count < longint'(MaxWidth) * MaxHeight) begin
				sum_col += col;
				sum_row += row;
				count++;
			end
			res = '0;
			res.mask = hit;
			if (last) begin
				res.done = 1'b1;
				if (count > 0) begin
					res.cx = CoordW'(sum_col / count);
					res.cy = CoordW'(sum_row / count);
				end else begin
					res.cx = '1;
					res.cy = '1;
					empty_frames++;
				end
				frames++;
				sum_col = 0;
				sum_row = 0;
				count = 0;
				col = 0;
				row = 0;
			end else begin
				col++;
				if (col >= w) begin
					col = 0;
					if (row < MaxHeight - 1) row++;
				end
			end
			pixels++;
			if (hit) hit_pixels++;
			result_q.insert(result_q.size(), res);
		endfunction

		function void check(logic mask, logic done, logic [CoordW-1:0] cx,
		                    logic [CoordW-1:0] cy);
			colour_result_t want;
			if (result_q.size() == 0) begin
				$error("result item with no pixel waiting: mask_on=%0d frame_done=%0d",
				       mask, done);
				errors++;
				return;
			end
			want = result_q.pop_front();
			if (mask !== want.mask) begin
				$error("mask_on: expected %0d, got %0d", want.mask, mask);
				errors++;
			end
			if (done !== want.done) begin
				$error("frame_done: expected %0d, got %0d", want.done, done);
				errors++;
			end
			if (cx !== want.cx) begin
				$error("center_x: expected %0d, got %0d", $signed(want.cx), $signed(cx));
				errors++;
			end
			if (cy !== want.cy) begin
				$error("center_y: expected %0d, got %0d", $signed(want.cy), $signed(cy));
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = CFG_TARGET_BLUE;
	logic [11:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // pixel_blue, pixel_green, pixel_red
	logic        s_tlast   = 1'b0; // frame_last
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // mask_on, center_x, center_y, zero
	logic        m_tlast;          // frame_done

	centroid_scoreboard sb = new();

	bit tx_idle  = 1'b0;
	bit rx_idle  = 1'b0;
	int hold_req = 0;

	color_window_mask_centroid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$error("timeout: block stopped moving items");
		$display("*** FAILED ***");
		$finish;
	end

	// output side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_tready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 99) < 20) begin
				gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				                                        : $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata[0], m_tlast, m_tdata[12:1], m_tdata[24:13]);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
	endtask

	// 8-bit registers get junk in the unused upper bits
	task automatic apply_config(input logic [7:0] tb, tg, tr, lb, lg, lr,
	                            input logic [11:0] fw);
		write_reg(CFG_TARGET_BLUE, {4'($urandom), tb});
		write_reg(CFG_TARGET_GREEN, {4'($urandom), tg});
		write_reg(CFG_TARGET_RED, {4'($urandom), tr});
		write_reg(CFG_TOL_BLUE, {4'($urandom), lb});
		write_reg(CFG_TOL_GREEN, {4'($urandom), lg});
		write_reg(CFG_TOL_RED, {4'($urandom), lr});
		write_reg(CFG_FRAME_WIDTH, fw);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_pixel(input logic [7:0] b, g, r, input logic last);
		int gap;
		gap = 0;
		if (tx_idle && $urandom_range(0, 99) < 25)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {r, g, b};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(b, g, r, last);
	endtask

	// sender stops until every result is back, then the block settles
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.result_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_sample(logic [7:0] target, logic [7:0] tol, bit near);
		int span;
		int v;
		if (!near) return 8'($urandom);
		span = sb.reach(target, tol) + 1;
		v = int'(target) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] pick_target();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_tol();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2, 3: return 8'($urandom);
			default: return 8'($urandom_range(1, 30));
		endcase
	endfunction

	initial begin
		int          phases;
		int          random_items;
		int          n_frames;
		int          len;
		int          w;
		int          near_rate;
		logic [11:0] fw;

		phases = 0;
		random_items = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: window 0..0 on every channel, the tolerance clamped by the target
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd15, 8'd15, 8'd15, 1'b0);
		send_pixel(8'd16, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd16, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd16, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		drain_results();

		// tolerance clamped to nothing at the top; width of zero acts as one
		apply_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 12'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		drain_results();

		// zero tolerance, full clamp at the bottom, width above the maximum
		apply_config(8'd128, 8'd0, 8'd128, 8'd0, 8'd255, 8'd255, 12'd4095);
		send_pixel(8'd128, 8'd0, 8'd1, 1'b0);
		send_pixel(8'd128, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd129, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd0, 8'd255, 1'b1);
		drain_results();

		while (random_items < 650) begin
			case ($urandom_range(0, 19))
				0: fw = 12'd0;
				1: fw = 12'd2048;
				2: fw = 12'd4095;
				3: fw = 12'd2047;
				4, 5, 6: fw = 12'($urandom_range(9, 64));
				default: fw = 12'($urandom_range(1, 8));
			endcase
			apply_config(pick_target(), pick_target(), pick_target(),
			             pick_tol(), pick_tol(), pick_tol(), fw);
			w = (fw == 0) ? 1 : (fw > MaxWidth) ? MaxWidth : fw;
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if (phases == 2) begin
				tx_idle = 1'b0;
				hold_req = 300;
			end
			n_frames = $urandom_range(3, 8);
			repeat (n_frames) begin
				near_rate = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(30, 90);
				if (w <= 16 && $urandom_range(0, 1) == 1)
					len = w * $urandom_range(1, 4);
				else
					len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++)
					send_pixel(pick_sample(sb.target_b, sb.tol_b,
					                       $urandom_range(0, 99) < near_rate),
					           pick_sample(sb.target_g, sb.tol_g,
					                       $urandom_range(0, 99) < near_rate),
					           pick_sample(sb.target_r, sb.tol_r,
					                       $urandom_range(0, 99) < near_rate),
					           i == len - 1);
				random_items += len;
			end
			drain_results();
			phases++;
		end

		$display("Run covered %0d pixel items in %0d frames, %0d of them matching.",
		         sb.pixels, sb.frames, sb.hit_pixels);
		$display("%0d random settings, %0d frames without a match.",
		         phases, sb.empty_frames);
		if (sb.errors == 0 && sb.result_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/cwmc_pkg.sv
rtl/core/cwmc_ctrl.sv
rtl/core/cwmc_dp.sv
rtl/core/color_window_mask_centroid.sv
dv/testbench.sv
